### hdl/gdrq_pkg.sv
// shared constants, types and codes for the graph degree and relay query block
package gdrq_pkg;

  localparam int MAX_NODES    = 64;
  localparam int NODE_W       = $clog2(MAX_NODES);        // row / column index
  localparam int CNT_W        = $clog2(MAX_NODES + 1);    // node count, degree
  localparam int NODE_FIELD_W = 7;
  localparam int CMD_W        = 2;
  localparam int WEIGHT_W     = 16;
  localparam int METRIC_W     = 17;
  localparam int SUM_W        = WEIGHT_W + 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // degree popcount tree: groups of eight bits, then one sum of the groups
  localparam int GROUP_W    = 8;
  localparam int NUM_GROUPS = MAX_NODES / GROUP_W;
  localparam int GRP_CNT_W  = $clog2(GROUP_W + 1);

  // job queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEGREE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELAY  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DEGREE = 2'd1,
    OP_RELAY  = 2'd2,
    OP_ZERO   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [NODE_W-1:0]   row_a;
    logic [NODE_W-1:0]   row_b;
    logic [WEIGHT_W-1:0] weight;
  } job_t;

endpackage

### hdl/graph_degree_and_relay_query.sv
// top level: configuration register, front end, job queue and back end
//
// in_*  : command stream, one command per transfer. tdata carries cmd, node_a,
//         node_b and weight. cmd 0 writes a link weight both ways (no result),
//         cmd 1 asks for the best connected node, cmd 2 for the best relay
//         between node_a and node_b; cmd 3 and writes to nodes outside the
//         matrix are dropped.
// out_* : one result transfer per query: answer_node and answer_metric.
// cfg_* : writes node_count, the number of nodes the queries look at; the user
//         must write it while no command is outstanding (not enforced here).
// steps : a write stores the entry, then its mirror in S_WRITE2. A degree
//         query scans in S_DEG, a relay query fetches both rows in S_FETCH_A
//         and S_FETCH_B, then scans in S_RELAY; an out-of-range query goes
//         straight to S_ANSWER. The scan loop reads one matrix row or one weight pair per cycle.
// a two-entry job queue lets commands be taken while the back end scans or
// while a result waits; a stalled receiver holds the result register and
// then the back end, and in_tready falls once the queue is full.
// reset clears the matrix at once through per-row valid bits; no sweep.
module graph_degree_and_relay_query import gdrq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,   // cmd, node_a, node_b, weight
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,  // answer_node, answer_metric
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [NODE_FIELD_W-1:0] cfg_data
);

  logic [NODE_FIELD_W-1:0] node_count_r;
  logic [CNT_W-1:0]        n_eff;
  logic                    q_push;
  job_t                    q_push_job;
  logic                    q_full;
  logic                    q_pop;
  job_t                    q_pop_job;
  logic                    q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // counts above the matrix size act as the full matrix
  assign n_eff = (int'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_r);

  gdrq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .n_eff     (n_eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  gdrq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  gdrq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_eff      (n_eff),
    .job_valid  (!q_empty),
    .job        (q_pop_job),
    .job_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hdl/gdrq_front.sv
// front end: decodes and classifies incoming commands into queue jobs
module gdrq_front import gdrq_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [CNT_W-1:0]     n_eff,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  logic [CMD_W-1:0]        cmd;
  logic [NODE_FIELD_W-1:0] node_a;
  logic [NODE_FIELD_W-1:0] node_b;
  logic [WEIGHT_W-1:0]     weight;
  logic                    a_in_mem;
  logic                    b_in_mem;
  logic                    a_in_use;
  logic                    b_in_use;
  logic                    keep;

  assign cmd    = in_tdata[1:0];
  assign node_a = in_tdata[8:2];
  assign node_b = in_tdata[15:9];
  assign weight = in_tdata[31:16];

  assign a_in_mem = (node_a != '0) && (int'(node_a) <= MAX_NODES);
  assign b_in_mem = (node_b != '0) && (int'(node_b) <= MAX_NODES);
  assign a_in_use = (node_a != '0) && (int'(node_a) <= int'(n_eff));
  assign b_in_use = (node_b != '0) && (int'(node_b) <= int'(n_eff));

  always_comb begin
    keep         = 1'b0;
    q_job.op     = OP_ZERO;
    q_job.row_a  = NODE_W'(node_a - NODE_FIELD_W'(1));
    q_job.row_b  = NODE_W'(node_b - NODE_FIELD_W'(1));
    q_job.weight = weight;
    unique case (cmd)
      CMD_WRITE: begin
        keep     = a_in_mem && b_in_mem;
        q_job.op = OP_WRITE;
      end
      CMD_DEGREE: begin
        keep     = 1'b1;
        q_job.op = (n_eff == '0) ? OP_ZERO : OP_DEGREE;
      end
      CMD_RELAY: begin
        keep     = 1'b1;
        q_job.op = (a_in_use && b_in_use) ? OP_RELAY : OP_ZERO;
      end
      default: begin
        // unused command code is dropped
        keep     = 1'b0;
        q_job.op = OP_ZERO;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

### hdl/gdrq_fifo.sv
// short job queue between the decoding front end and the executing back end
module gdrq_fifo import gdrq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### hdl/gdrq_back.sv
// back end: link storage, degree and relay scans, result register
module gdrq_back import gdrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CNT_W-1:0]      n_eff,
  input  logic                  job_valid,
  input  job_t                  job,
  output logic                  job_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WRITE2  = 7'b0000010,
    S_DEG     = 7'b0000100,
    S_FETCH_A = 7'b0001000,
    S_FETCH_B = 7'b0010000,
    S_RELAY   = 7'b0100000,
    S_ANSWER  = 7'b1000000
  } state_t;

  // weights, and a nonzero map that also stands in for the cleared state
  logic [WEIGHT_W-1:0]  wt_mem [MAX_NODES*MAX_NODES];
  logic [MAX_NODES-1:0] nz_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid_r;

  state_t state_r;
  state_t state_nxt;

  logic [NODE_W-1:0]   row_a_r;
  logic [NODE_W-1:0]   row_b_r;
  logic [WEIGHT_W-1:0] weight_r;

  logic                job_go;
  logic                wr_en;
  logic [NODE_W-1:0]   wr_row;
  logic [NODE_W-1:0]   wr_col;
  logic [WEIGHT_W-1:0] wr_w;
  logic                wr_nz;
  logic [MAX_NODES-1:0] wr_row_init;
  logic [NODE_W-1:0]   nz_raddr;
  logic                start_scan;
  logic                load_out;
  logic                clear_best;

  logic [MAX_NODES-1:0] nz_rdata_r;
  logic                 nz_rvalid_r;
  logic [MAX_NODES-1:0] nz_row;
  logic [MAX_NODES-1:0] col_mask;
  logic [MAX_NODES-1:0] masked_row;
  logic [MAX_NODES-1:0] row_a_bits_r;
  logic [MAX_NODES-1:0] row_b_bits_r;
  logic [WEIGHT_W-1:0]  wt_a_r;
  logic [WEIGHT_W-1:0]  wt_b_r;

  logic [CNT_W-1:0]  scan_r;
  logic              issue_busy_r;
  logic [NODE_W-1:0] scan_idx;
  logic              scan_last;

  logic              s1_v_r;
  logic [NODE_W-1:0] s1_idx_r;
  logic              s1_last_r;
  logic              s2_v_r;
  logic [NODE_W-1:0] s2_idx_r;
  logic              s2_last_r;
  logic [GRP_CNT_W-1:0] part_r   [NUM_GROUPS];
  logic [GRP_CNT_W-1:0] part_nxt [NUM_GROUPS];
  logic              s3_v_r;
  logic [NODE_W-1:0] s3_idx_r;
  logic              s3_last_r;
  logic [CNT_W-1:0]  deg_r;
  logic [CNT_W-1:0]  deg_nxt;

  logic                    found_r;
  logic [NODE_FIELD_W-1:0] best_node_r;
  logic [METRIC_W-1:0]     best_metric_r;
  logic                    deg_upd;
  logic                    rel_qual;
  logic [SUM_W-1:0]        rel_sum;
  logic                    rel_upd;

  logic                    out_valid_r;
  logic [NODE_FIELD_W-1:0] out_node_r;
  logic [METRIC_W-1:0]     out_metric_r;

  function automatic logic [GRP_CNT_W-1:0] grp_count(input logic [GROUP_W-1:0] v);
    logic [GRP_CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      c = c + GRP_CNT_W'(v[i]);
    end
    return c;
  endfunction

  assign scan_idx  = scan_r[NODE_W-1:0];
  assign scan_last = (CNT_W'(scan_r + CNT_W'(1)) == n_eff);
  assign job_go    = (state_r == S_IDLE) && job_valid;
  assign job_pop   = job_go;

  always_comb begin
    state_nxt  = state_r;
    wr_en      = 1'b0;
    wr_row     = job.row_a;
    wr_col     = job.row_b;
    wr_w       = job.weight;
    nz_raddr   = job.row_a;
    start_scan = 1'b0;
    load_out   = 1'b0;
    clear_best = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          clear_best = 1'b1;
          unique case (job.op)
            OP_WRITE: begin
              wr_en     = 1'b1;
              state_nxt = S_WRITE2;
            end
            OP_DEGREE: begin
              start_scan = 1'b1;
              state_nxt  = S_DEG;
            end
            OP_RELAY: state_nxt = S_FETCH_A;
            OP_ZERO:  state_nxt = S_ANSWER;
          endcase
        end
      end
      S_WRITE2: begin
        // mirror entry
        wr_en     = 1'b1;
        wr_row    = row_b_r;
        wr_col    = row_a_r;
        wr_w      = weight_r;
        state_nxt = S_IDLE;
      end
      S_DEG: begin
        nz_raddr = scan_idx;
        if (s3_v_r && s3_last_r) begin
          state_nxt = S_ANSWER;
        end
      end
      S_FETCH_A: begin
        nz_raddr  = row_b_r;
        state_nxt = S_FETCH_B;
      end
      S_FETCH_B: begin
        start_scan = 1'b1;
        state_nxt  = S_RELAY;
      end
      S_RELAY: begin
        if (s1_v_r && s1_last_r) begin
          state_nxt = S_ANSWER;
        end
      end
      S_ANSWER: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_go) begin
      row_a_r  <= job.row_a;
      row_b_r  <= job.row_b;
      weight_r <= job.weight;
    end
  end

  // storage writes; a row never written reads as all zero through its valid bit
  assign wr_nz = (wr_w != '0);

  always_comb begin
    wr_row_init         = '0;
    wr_row_init[wr_col] = wr_nz;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wt_mem[{wr_row, wr_col}] <= wr_w;
      if (row_valid_r[wr_row]) begin
        nz_mem[wr_row][wr_col] <= wr_nz;
      end else begin
        nz_mem[wr_row] <= wr_row_init;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    nz_rdata_r <= nz_mem[nz_raddr];
    wt_a_r     <= wt_mem[{row_a_r, scan_idx}];
    wt_b_r     <= wt_mem[{row_b_r, scan_idx}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_rvalid_r <= 1'b0;
    end else begin
      nz_rvalid_r <= row_valid_r[nz_raddr];
    end
  end

  assign nz_row = nz_rvalid_r ? nz_rdata_r : '0;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      col_mask[i] = (i < int'(n_eff));
    end
  end

  assign masked_row = nz_row & col_mask;

  always_ff @(posedge clk) begin
    if (state_r == S_FETCH_A) begin
      row_a_bits_r <= nz_row;
    end
    if (state_r == S_FETCH_B) begin
      row_b_bits_r <= nz_row;
    end
  end

  // scan counter, one node per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_busy_r <= 1'b0;
      scan_r       <= '0;
    end else if (start_scan) begin
      issue_busy_r <= 1'b1;
      scan_r       <= '0;
    end else if (issue_busy_r) begin
      scan_r <= scan_r + CNT_W'(1);
      if (scan_last) begin
        issue_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_nxt[g] = grp_count(masked_row[g*GROUP_W +: GROUP_W]);
    end
    deg_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      deg_nxt = deg_nxt + CNT_W'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue_busy_r;
      s2_v_r <= s1_v_r && (state_r == S_DEG);
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= scan_idx;
    s1_last_r <= scan_last;
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    part_r    <= part_nxt;
    s3_idx_r  <= s2_idx_r;
    s3_last_r <= s2_last_r;
    deg_r     <= deg_nxt;
  end

  // best candidate; strict compare keeps the lowest index on a tie
  assign deg_upd  = s3_v_r && (!found_r || (METRIC_W'(deg_r) > best_metric_r));
  assign rel_qual = row_a_bits_r[s1_idx_r] && row_b_bits_r[s1_idx_r];
  assign rel_sum  = SUM_W'(wt_a_r) + SUM_W'(wt_b_r);
  assign rel_upd  = s1_v_r && (state_r == S_RELAY) && rel_qual &&
                    (!found_r || (METRIC_W'(rel_sum) < best_metric_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r       <= 1'b0;
      best_node_r   <= '0;
      best_metric_r <= '0;
    end else if (clear_best) begin
      found_r       <= 1'b0;
      best_node_r   <= '0;
      best_metric_r <= '0;
    end else if (deg_upd) begin
      found_r       <= 1'b1;
      best_node_r   <= NODE_FIELD_W'(s3_idx_r) + NODE_FIELD_W'(1);
      best_metric_r <= METRIC_W'(deg_r);
    end else if (rel_upd) begin
      found_r       <= 1'b1;
      best_node_r   <= NODE_FIELD_W'(s1_idx_r) + NODE_FIELD_W'(1);
      best_metric_r <= METRIC_W'(rel_sum);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_node_r   <= best_node_r;
      out_metric_r <= best_metric_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_metric_r, out_node_r};

endmodule

### dv/tb_top.sv
// testbench for graph_degree_and_relay_query: adjacency matrix predictor with a result scoreboard
module tb_top import gdrq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LIMIT_NS        = 4_000_000;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] node;
    logic [METRIC_W-1:0]     metric;
  } answer_t;

  class relay_scoreboard;
    logic [WEIGHT_W-1:0] link_w [MAX_NODES][MAX_NODES];
    int unsigned         active_limit;
    answer_t             expected_answers[$];
    int unsigned         mismatches;

    function new();
      foreach (link_w[r, c]) link_w[r][c] = '0;
      active_limit = 0;
      mismatches = 0;
    endfunction

    function void set_node_count(logic [NODE_FIELD_W-1:0] value);
      active_limit = (value > MAX_NODES) ? MAX_NODES : value;
    endfunction

    function int unsigned outstanding();
      return expected_answers.size();
    endfunction

    // node with the most nonzero row entries over the active square
    function answer_t best_connected();
      answer_t     best;
      int unsigned deg;
      bit          found;
      best = '0;
      found = 1'b0;
      for (int r = 0; r < active_limit; r++) begin
        deg = 0;
        for (int c = 0; c < active_limit; c++)
          if (link_w[r][c] != 0) deg++;
        if (!found || deg > best.metric) begin
          found = 1'b1;
          best.node = r + 1;
          best.metric = deg;
        end
      end
      return best;
    endfunction

    // intermediate node with the shortest two-hop path from src to dst
    function answer_t best_relay(int unsigned src, int unsigned dst);
      answer_t     best;
      int unsigned hop_in, hop_out, total;
      bit          found;
      best = '0;
      found = 1'b0;
      if (src >= 1 && src <= active_limit && dst >= 1 && dst <= active_limit) begin
        for (int z = 0; z < active_limit; z++) begin
          hop_in = link_w[src-1][z];
          hop_out = link_w[z][dst-1];
          total = hop_in + hop_out;
          if (hop_in != 0 && hop_out != 0 && (!found || total < best.metric)) begin
            found = 1'b1;
            best.node = z + 1;
            best.metric = total;
          end
        end
      end
      return best;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [NODE_FIELD_W-1:0] a,
                               logic [NODE_FIELD_W-1:0] b, logic [WEIGHT_W-1:0] w);
      int unsigned ia, ib;
      ia = a;
      ib = b;
      case (cmd)
        CMD_WRITE: begin
          if (ia >= 1 && ia <= MAX_NODES && ib >= 1 && ib <= MAX_NODES) begin
            link_w[ia-1][ib-1] = w;
            link_w[ib-1][ia-1] = w;
          end
        end
        CMD_DEGREE: expected_answers.push_back(best_connected());
        CMD_RELAY:  expected_answers.push_back(best_relay(ia, ib));
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(answer_t got);
      answer_t want;
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("result node %0d metric %0d with no query outstanding",
                                  got.node, got.metric));
      end else begin
        want = expected_answers.pop_front();
        if (got.node !== want.node)
          report_mismatch($sformatf("answer_node %0d, expected %0d", got.node, want.node));
        if (got.metric !== want.metric)
          report_mismatch($sformatf("answer_metric %0d, expected %0d",
                                    got.metric, want.metric));
      end
    endtask

    task finish_check();
      if (expected_answers.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;   // cmd, node_a, node_b, weight
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;  // answer_node, answer_metric
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [NODE_FIELD_W-1:0] cfg_data;

  relay_scoreboard sb = new();
  int unsigned     burst_left = 0;
  bit              hold_off_req = 1'b0;

  always #2 clk = ~clk;

  graph_degree_and_relay_query dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.node = out_tdata[NODE_FIELD_W-1:0];
      got.metric = out_tdata[NODE_FIELD_W +: METRIC_W];
      sb.check_result(got);
    end
  end

  // receiver: segments of free flow, random stalls or a sparse ready pattern
  initial begin : result_sink
    int unsigned seg_len, style, period;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        seg_len = $urandom_range(4, 60);
        style = $urandom_range(0, 2);
        period = $urandom_range(2, 8);
        for (int i = 0; i < seg_len; i++) begin
          case (style)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 99) >= 35);
            default: out_tready <= (i % period == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("graph_degree_and_relay_query verification failed");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [NODE_FIELD_W-1:0] a,
                          input logic [NODE_FIELD_W-1:0] b, input logic [WEIGHT_W-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {w, b, a, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, a, b, w);
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NODE_FIELD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_node_count(value);
  endtask

  function automatic logic [NODE_FIELD_W-1:0] pick_node(int unsigned lim, bit wide);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (lim > 0 && roll < 85) return $urandom_range(1, lim);
    if (wide && roll >= 95) return $urandom_range(0, 127);
    return $urandom_range(1, MAX_NODES);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 50) return $urandom_range(1, 3);   // small weights give ties
    if (roll < 58) return 16'hFFFF - $urandom_range(0, 2);
    return $urandom;
  endfunction

  task automatic random_phase(input int unsigned setting, input int unsigned items,
                              input bit with_hold);
    int unsigned done, roll, lim;
    bit          held, paused;
    logic [NODE_FIELD_W-1:0] bad;
    wait_idle();
    write_node_count(setting);
    lim = (setting > MAX_NODES) ? MAX_NODES : setting;
    done = 0;
    held = 1'b0;
    paused = 1'b0;
    while (done < items) begin
      if (with_hold && !held && done >= items / 4) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && done >= items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_cmd(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end else if (roll < 5) begin
        bad = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_NODES + 1, 127));
        if (roll == 3) send_cmd(CMD_WRITE, bad, pick_node(lim, 1'b0), pick_weight());
        else send_cmd(CMD_WRITE, pick_node(lim, 1'b0), bad, pick_weight());
      end else if (roll < 55) begin
        send_cmd(CMD_WRITE, pick_node(lim, 1'b0), pick_node(lim, 1'b0), pick_weight());
        done++;
      end else if (roll < 75) begin
        send_cmd(CMD_DEGREE, $urandom, $urandom, $urandom);
        done++;
      end else begin
        send_cmd(CMD_RELAY, pick_node(lim, 1'b1), pick_node(lim, 1'b1), $urandom);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_counts[12] = '{6, 64, 3, 0, 10, 127, 1, 5, 2, 33, 8, 4};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty network straight after reset
    send_cmd(CMD_DEGREE, 7'd1, 7'd1, 16'd0);
    send_cmd(CMD_RELAY, 7'd1, 7'd1, 16'd0);
    send_cmd(CMD_WRITE, 7'd1, 7'd2, 16'd5);

    wait_idle();
    write_node_count(7'd4);
    send_cmd(CMD_WRITE, 7'd1, 7'd1, 16'd9);          // self link
    send_cmd(CMD_WRITE, 7'd2, 7'd3, 16'd7);
    send_cmd(CMD_WRITE, 7'd1, 7'd3, 16'hFFFF);
    send_cmd(CMD_WRITE, 7'd3, 7'd3, 16'hFFFF);
    send_cmd(CMD_WRITE, 7'd0, 7'd2, 16'd3);          // outside the matrix, dropped
    send_cmd(CMD_WRITE, 7'd65, 7'd1, 16'd3);
    send_cmd(CMD_WRITE, 7'd127, 7'd127, 16'd1);
    send_cmd(CMD_WRITE, 7'd10, 7'd11, 16'd4);        // beyond node_count, kept
    send_cmd(CMD_UNUSED, 7'd127, 7'd127, 16'hFFFF);
    send_cmd(CMD_DEGREE, 7'd0, 7'd0, 16'd0);
    send_cmd(CMD_RELAY, 7'd1, 7'd3, 16'd0);
    send_cmd(CMD_RELAY, 7'd3, 7'd3, 16'd0);
    send_cmd(CMD_RELAY, 7'd1, 7'd5, 16'd0);
    send_cmd(CMD_RELAY, 7'd0, 7'd1, 16'd0);
    send_cmd(CMD_RELAY, 7'd4, 7'd4, 16'd0);
    send_cmd(CMD_WRITE, 7'd2, 7'd3, 16'd0);          // link removed
    send_cmd(CMD_RELAY, 7'd1, 7'd3, 16'd0);
    send_cmd(CMD_RELAY, 7'd3, 7'd3, 16'd0);          // tie at the largest sum
    send_cmd(CMD_DEGREE, 7'd0, 7'd0, 16'd0);

    wait_idle();
    write_node_count(7'd12);
    send_cmd(CMD_DEGREE, 7'd0, 7'd0, 16'd0);
    send_cmd(CMD_RELAY, 7'd10, 7'd11, 16'd0);
    send_cmd(CMD_RELAY, 7'd10, 7'd10, 16'd0);

    foreach (phase_counts[i])
      random_phase(phase_counts[i], 140, (i == 5));

    wait_idle();
    sb.finish_check();
    if (sb.mismatches == 0)
      $display("graph_degree_and_relay_query verification clean");
    else
      $display("graph_degree_and_relay_query verification failed");
    $finish;
  end
endmodule
